// ===== hw/rtl/rgb565_pair_palette_ditherer_defines.svh =====
// Assertion macros for the pair palette ditherer.
`ifndef RGB565_PAIR_PALETTE_DITHERER_DEFINES_SVH
`define RGB565_PAIR_PALETTE_DITHERER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rppd_pkg.sv =====
// Shared types, constants and table functions for the pair palette ditherer.
package rppd_pkg;

  localparam int PAL_N      = 6;
  localparam int NUM_STAGES = 9;

  localparam int NOISE_MOD   = 129 * 127;
  localparam int NOISE_THIRD = NOISE_MOD / 3;
  localparam int X_STEP      = 127 * 29;
  localparam int Y_STEP      = 129 * 48;
  localparam int FAST_GAIN   = 70;

  localparam int W5_MUL = 255 * 33826;  // ~255/31 scaled by 2^20
  localparam int W6_MUL = 255 * 16645;  // ~255/63 scaled by 2^20

  localparam logic [1:0] CFG_MODE         = 2'd0;
  localparam logic [1:0] CFG_TEXT_GAIN    = 2'd1;
  localparam logic [1:0] CFG_QUALITY_GAIN = 2'd2;

  localparam logic [7:0] TEXT_GAIN_RST    = 8'd70;
  localparam logic [7:0] QUALITY_GAIN_RST = 8'd140;

  typedef enum logic [1:0] {
    MODE_QUALITY = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_FAST    = 2'd2,
    MODE_FASTEST = 2'd3
  } mode_e;

  typedef logic [NUM_STAGES-1:0] stage_en_t;
  typedef logic [0:2][7:0] rgb_t;
  typedef logic [20:0] score_t;

  typedef struct packed {
    score_t     best;
    logic [2:0] best_j;
    logic [17:0] near_a;
    logic [17:0] near_b;
  } lane_res_t;

  localparam logic [0:3][0:3][7:0] BAYER = '{
    '{8'd0,   8'd128, 8'd32,  8'd160},
    '{8'd192, 8'd64,  8'd224, 8'd96},
    '{8'd48,  8'd176, 8'd16,  8'd144},
    '{8'd240, 8'd112, 8'd208, 8'd80}
  };

  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(W5_MUL);
    return p[27:20];
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(W6_MUL);
    return p[27:20];
  endfunction

  function automatic logic signed [7:0] bayer_bias(logic [1:0] r, logic [1:0] c);
    logic signed [15:0] t;
    t = (16'sd2 * $signed({8'd0, BAYER[r][c]}) - 16'sd255) * 16'(FAST_GAIN);
    return 8'(t >>> 8);
  endfunction

  function automatic rgb_t pal_rgb(logic [2:0] k);
    rgb_t c;
    unique case (k)
      3'd1:    c = '{8'd255, 8'd255, 8'd255};
      3'd2:    c = '{8'd255, 8'd243, 8'd56};
      3'd3:    c = '{8'd191, 8'd0,   8'd0};
      3'd4:    c = '{8'd100, 8'd64,  8'd255};
      3'd5:    c = '{8'd67,  8'd138, 8'd28};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

  function automatic logic [3:0] pal_code(logic [2:0] k);
    logic [3:0] c;
    unique case (k)
      3'd1:    c = 4'h1;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h3;
      3'd4:    c = 4'h5;
      3'd5:    c = 4'h6;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/rppd_if.sv =====
// Channel interfaces: pixel pair input, packed result output, register writes.
interface rppd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_pixel;
  logic [15:0] second_pixel;
  logic [8:0]  column;
  logic [9:0]  row;
  modport source (output valid, first_pixel, second_pixel, column, row, input ready);
  modport sink   (input valid, first_pixel, second_pixel, column, row, output ready);
endinterface

interface rppd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_pair;
  modport source (output valid, packed_pair, input ready);
  modport sink   (input valid, packed_pair, output ready);
endinterface

interface rppd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rppd_phase.sv =====
// Noise phase generator: per-pair base offsets modulo 129*127, three stages.
module rppd_phase import rppd_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [8:0]  column_i,
  input  logic [9:0]  row_i,
  output logic [13:0] base0_o,
  output logic [13:0] base1_o
);

  logic [22:0] a_q;
  logic [20:0] b_q;
  logic [13:0] am_q, bm_q, am_d, bm_d;
  logic [13:0] base0_q, base1_q, base0_d, base1_d;
  logic [14:0] fa, fb;
  logic signed [15:0] t0, t1;

  always_comb begin
    fa = 15'(a_q[22:14]) + 15'(a_q[13:0]);
    fb = 15'(b_q[20:14]) + 15'(b_q[13:0]);
    am_d = (fa >= 15'(NOISE_MOD)) ? 14'(fa - 15'(NOISE_MOD)) : fa[13:0];
    bm_d = (fb >= 15'(NOISE_MOD)) ? 14'(fb - 15'(NOISE_MOD)) : fb[13:0];
    t0 = $signed({2'b0, am_q}) - $signed({2'b0, bm_q});
    base0_d = (t0 < 0) ? 14'(t0 + 16'(NOISE_MOD)) : t0[13:0];
    t1 = $signed({2'b0, base0_d}) - 16'(X_STEP);
    base1_d = (t1 < 0) ? 14'(t1 + 16'(NOISE_MOD)) : t1[13:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q <= 23'(row_i) * 23'(Y_STEP);
      b_q <= 21'({1'b0, column_i} + 10'd1) * 21'(X_STEP);
    end
    if (en_i[1]) begin
      am_q <= am_d;
      bm_q <= bm_d;
    end
    if (en_i[2]) begin
      base0_q <= base0_d;
      base1_q <= base1_d;
    end
  end

  assign base0_o = base0_q;
  assign base1_o = base1_q;

endmodule

// ===== hw/rtl/rppd_pix_lane.sv =====
// Per-pixel lane: widening, Bayer/noise/no bias, clamping; stages one to six.
module rppd_pix_lane import rppd_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [15:0] pixel_i,
  input  logic [1:0]  bcol_i,
  input  logic [1:0]  brow_i,
  input  logic [13:0] base_i,
  input  mode_e       mode_i,
  input  logic [7:0]  gain_i,
  output rgb_t        ch_o
);

  rgb_t                ch_q [5];
  logic signed [7:0]   by_q [5];
  logic signed [15:0]  bn_q [3];
  logic signed [15:0]  bn_d [3];
  logic signed [9:0]   bias_q [3];
  logic signed [9:0]   bias_d [3];
  rgb_t                out_q, out_d;
  logic [13:0]         bg, bb;
  logic signed [14:0]  tg, tb;
  logic signed [16:0]  sum;
  logic signed [8:0]   gs;
  logic signed [25:0]  pc;
  logic signed [24:0]  po;
  logic signed [9:0]   common;
  logic signed [10:0]  vn, vb;
  rgb_t                wide;

  always_comb begin
    wide = '{widen5(pixel_i[15:11]), widen6(pixel_i[10:5]), widen5(pixel_i[4:0])};
    tg = $signed({1'b0, base_i}) - 15'(NOISE_THIRD);
    bg = (tg < 0) ? 14'(tg + 15'(NOISE_MOD)) : tg[13:0];
    tb = $signed({1'b0, bg}) - 15'(NOISE_THIRD);
    bb = (tb < 0) ? 14'(tb + 15'(NOISE_MOD)) : tb[13:0];
    bn_d[0] = $signed({1'b0, base_i, 1'b0}) - 16'(NOISE_MOD - 1);
    bn_d[1] = $signed({1'b0, bg, 1'b0}) - 16'(NOISE_MOD - 1);
    bn_d[2] = $signed({1'b0, bb, 1'b0}) - 16'(NOISE_MOD - 1);
    gs  = $signed({1'b0, gain_i});
    sum = 17'(bn_q[0]) + 17'(bn_q[1]) + 17'(bn_q[2]);
    pc  = 26'(sum) * 26'(gs);
    common = 10'(pc >>> 16);
    for (int c = 0; c < 3; c++) begin
      po = 25'(bn_q[c]) * 25'(gs);
      bias_d[c] = common + 10'(po >>> 16);
    end
    for (int c = 0; c < 3; c++) begin
      vn = $signed({3'b0, ch_q[4][c]}) + 11'(bias_q[c]);
      vb = $signed({3'b0, ch_q[4][c]}) + 11'(by_q[4]);
      unique case (mode_i)
        MODE_FASTEST: out_d[c] = ch_q[4][c];
        MODE_FAST:    out_d[c] = (vb < 0) ? 8'd0 : ((vb > 11'sd255) ? 8'd255 : vb[7:0]);
        default:      out_d[c] = (vn < 0) ? 8'd0 : ((vn > 11'sd255) ? 8'd255 : vn[7:0]);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ch_q[0] <= wide;
      by_q[0] <= bayer_bias(brow_i, bcol_i);
    end
    for (int k = 1; k < 5; k++) begin
      if (en_i[k]) begin
        ch_q[k] <= ch_q[k-1];
        by_q[k] <= by_q[k-1];
      end
    end
    if (en_i[3]) bn_q <= bn_d;
    if (en_i[4]) bias_q <= bias_d;
    if (en_i[5]) out_q <= out_d;
  end

  assign ch_o = out_q;

endmodule

// ===== hw/rtl/rppd_pair_lane.sv =====
// Pair scoring lane: fixed left colour against all right colours; stages seven, eight.
module rppd_pair_lane import rppd_pkg::*; (
  input  logic       clk_i,
  input  stage_en_t  en_i,
  input  logic [2:0] lane_idx_i,
  input  rgb_t       a_i,
  input  rgb_t       b_i,
  output lane_res_t  res_o
);

  logic [17:0] ia_q, nb_q, ia_d, nb_d;
  logic [17:0] ib_q [PAL_N];
  logic [17:0] ib_d [PAL_N];
  logic [19:0] jt_q [PAL_N];
  logic [19:0] jt_d [PAL_N];
  lane_res_t   res_q, res_d;
  rgb_t        pi, pj;
  logic signed [9:0]  da [3];
  logic signed [9:0]  db, dn;
  logic signed [10:0] s;
  score_t      d;

  always_comb begin
    pi = pal_rgb(lane_idx_i);
    ia_d = '0;
    nb_d = '0;
    for (int c = 0; c < 3; c++) begin
      da[c] = $signed({2'b0, a_i[c]}) - $signed({2'b0, pi[c]});
      dn    = $signed({2'b0, b_i[c]}) - $signed({2'b0, pi[c]});
      ia_d  = ia_d + 18'($unsigned(20'(da[c]) * 20'(da[c])));
      nb_d  = nb_d + 18'($unsigned(20'(dn) * 20'(dn)));
    end
    for (int j = 0; j < PAL_N; j++) begin
      pj = pal_rgb(3'(j));
      ib_d[j] = '0;
      jt_d[j] = '0;
      for (int c = 0; c < 3; c++) begin
        db = $signed({2'b0, b_i[c]}) - $signed({2'b0, pj[c]});
        s  = 11'(da[c]) + 11'(db);
        ib_d[j] = ib_d[j] + 18'($unsigned(20'(db) * 20'(db)));
        jt_d[j] = jt_d[j] + 20'($unsigned(22'(s) * 22'(s)));
      end
    end
    res_d.best   = '1;
    res_d.best_j = '0;
    for (int j = 0; j < PAL_N; j++) begin
      d = score_t'(ia_q) + score_t'(ib_q[j]) + score_t'(jt_q[j]);
      if (j == 0 || d < res_d.best) begin
        res_d.best   = d;
        res_d.best_j = 3'(j);
      end
    end
    res_d.near_a = ia_q;
    res_d.near_b = nb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      ia_q <= ia_d;
      nb_q <= nb_d;
      ib_q <= ib_d;
      jt_q <= jt_d;
    end
    if (en_i[7]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/rppd_merge.sv =====
// Merge stage: picks the best lane, or per-pixel nearest colours in fastest mode.
module rppd_merge import rppd_pkg::*; (
  input  logic       clk_i,
  input  stage_en_t  en_i,
  input  mode_e      mode_i,
  input  lane_res_t  res_i [PAL_N],
  output logic [7:0] packed_o
);

  logic [7:0]  packed_q, packed_d;
  score_t      best;
  logic [17:0] bna, bnb;
  logic [2:0]  bi, bj, ba, bb;

  always_comb begin
    best = res_i[0].best;
    bi = '0;
    bj = res_i[0].best_j;
    bna = res_i[0].near_a;
    bnb = res_i[0].near_b;
    ba = '0;
    bb = '0;
    for (int i = 1; i < PAL_N; i++) begin
      if (res_i[i].best < best) begin
        best = res_i[i].best;
        bi = 3'(i);
        bj = res_i[i].best_j;
      end
      if (res_i[i].near_a < bna) begin
        bna = res_i[i].near_a;
        ba = 3'(i);
      end
      if (res_i[i].near_b < bnb) begin
        bnb = res_i[i].near_b;
        bb = 3'(i);
      end
    end
    if (mode_i == MODE_FASTEST) packed_d = {pal_code(ba), pal_code(bb)};
    else                        packed_d = {pal_code(bi), pal_code(bj)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) packed_q <= packed_d;
  end

  assign packed_o = packed_q;

endmodule

// ===== hw/rtl/rgb565_pair_palette_ditherer.sv =====
// Top level of the RGB565 pixel-pair six-colour palette ditherer.
//
//  channel  dir  handshake     payload
//  pix_i    in   valid/ready   first_pixel, second_pixel, column, row
//  res_o    out  valid/ready   packed_pair
//  cfg_i    in   valid/ready   index, data (ready always high)
//
// Nine-stage pipeline: one pixel pair per cycle while the output is not stalled.
// The phase generator and two pixel lanes fill stages one to six, six pair
// lanes score stages seven and eight, the merge stage registers the result.
// Each stage holds only while its successor is full and stalled, so bubbles
// squeeze out under backpressure. Reset clears valids and config registers.
`include "rgb565_pair_palette_ditherer_defines.svh"

module rgb565_pair_palette_ditherer import rppd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rppd_in_if.sink   pix_i,
  rppd_out_if.source res_o,
  rppd_cfg_if.sink  cfg_i
);

  mode_e      mode_q;
  logic [7:0] text_gain_q, quality_gain_q, gain;
  logic [NUM_STAGES-1:0] v_q;
  stage_en_t  en;
  logic [13:0] base0, base1;
  logic [1:0]  bcol1;
  rgb_t        ch_a, ch_b;
  lane_res_t   lres [PAL_N];

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || res_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pix_i.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_QUALITY;
      text_gain_q    <= TEXT_GAIN_RST;
      quality_gain_q <= QUALITY_GAIN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MODE:         mode_q <= mode_e'(cfg_i.data[1:0]);
        CFG_TEXT_GAIN:    text_gain_q <= cfg_i.data;
        CFG_QUALITY_GAIN: quality_gain_q <= cfg_i.data;
        default:          ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = en[0];
  assign res_o.valid = v_q[NUM_STAGES-1];
  assign gain  = (mode_q == MODE_TEXT) ? text_gain_q : quality_gain_q;
  assign bcol1 = pix_i.column[1:0] + 2'd1;

  rppd_phase u_phase (
    .clk_i, .en_i(en), .column_i(pix_i.column), .row_i(pix_i.row),
    .base0_o(base0), .base1_o(base1)
  );

  rppd_pix_lane u_lane_a (
    .clk_i, .en_i(en), .pixel_i(pix_i.first_pixel), .bcol_i(pix_i.column[1:0]),
    .brow_i(pix_i.row[1:0]), .base_i(base0), .mode_i(mode_q), .gain_i(gain),
    .ch_o(ch_a)
  );

  rppd_pix_lane u_lane_b (
    .clk_i, .en_i(en), .pixel_i(pix_i.second_pixel), .bcol_i(bcol1),
    .brow_i(pix_i.row[1:0]), .base_i(base1), .mode_i(mode_q), .gain_i(gain),
    .ch_o(ch_b)
  );

  for (genvar i = 0; i < PAL_N; i++) begin : g_pair
    rppd_pair_lane u_pair (
      .clk_i, .en_i(en), .lane_idx_i(3'(i)), .a_i(ch_a), .b_i(ch_b),
      .res_o(lres[i])
    );
  end

  rppd_merge u_merge (
    .clk_i, .en_i(en), .mode_i(mode_q), .res_i(lres), .packed_o(res_o.packed_pair)
  );

  `RPPD_ASSERT_NOW(a_ready_when_drained, !res_o.valid || res_o.ready, pix_i.ready, "input stalled with free output")
  `RPPD_ASSERT_NEXT(a_accept_fills, pix_i.valid && pix_i.ready, v_q[0], "accepted transaction lost")
  `RPPD_ASSERT_NOW(a_code_valid, res_o.valid, res_o.packed_pair[7:4] != 4'h4 && res_o.packed_pair[7:4] <= 4'h6 && res_o.packed_pair[3:0] != 4'h4 && res_o.packed_pair[3:0] <= 4'h6, "bad palette code")

endmodule

// ===== tb/rppd_checker.sv =====
// Pair ditherer checker: watches all channels, predicts packed pairs, compares results.
module rppd_checker import rppd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rppd_in_if          pix,
  rppd_out_if         res,
  rppd_cfg_if         cfg,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_R[6] = '{0, 255, 255, 191, 100, 67};
  localparam int PAL_G[6] = '{0, 255, 243, 0, 64, 138};
  localparam int PAL_B[6] = '{0, 255, 56, 0, 255, 28};
  localparam logic [3:0] PAL_IDX[6] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h5, 4'h6};
  localparam int ORDERED[4][4] = '{
    '{0, 128, 32, 160}, '{192, 64, 224, 96}, '{48, 176, 16, 144}, '{240, 112, 208, 80}};

  mode_e      cur_mode;
  logic [7:0] text_gain;
  logic [7:0] quality_gain;
  logic [7:0] expected_pairs[$];
  int         fails;
  int         depth = 0;

  assign fail_count_o = fails;
  assign pending_o    = depth;

  typedef int chan_t[3];

  function automatic chan_t expand565(logic [15:0] c);
    chan_t ch;
    ch[0] = int'(c[15:11]) * 255 / 31;
    ch[1] = int'(c[10:5]) * 255 / 63;
    ch[2] = int'(c[4:0]) * 255 / 31;
    return ch;
  endfunction

  function automatic int sat8(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic int modstep(longint v);
    longint r;
    r = v % NOISE_MOD;
    return int'(r < 0 ? r + NOISE_MOD : r);
  endfunction

  function automatic int dist2(chan_t ch, int k);
    int dr, dg, db;
    dr = ch[0] - PAL_R[k];
    dg = ch[1] - PAL_G[k];
    db = ch[2] - PAL_B[k];
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic logic [3:0] closest(chan_t ch);
    longint best;
    logic [3:0] idx;
    best = 64'h7fffffff_ffffffff;
    idx = 4'h1;
    for (int k = 0; k < 6; k++) begin
      if (dist2(ch, k) < best) begin
        best = dist2(ch, k);
        idx = PAL_IDX[k];
      end
    end
    return idx;
  endfunction

  function automatic logic [7:0] best_pair(chan_t a, chan_t b);
    longint best, d;
    logic [7:0] idx;
    int s;
    int pa[3], pb[3];
    best = 64'h7fffffff_ffffffff;
    idx = 8'h11;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 6; j++) begin
        pa = '{PAL_R[i], PAL_G[i], PAL_B[i]};
        pb = '{PAL_R[j], PAL_G[j], PAL_B[j]};
        d = dist2(a, i) + dist2(b, j);
        for (int c = 0; c < 3; c++) begin
          s = (a[c] - pa[c]) + (b[c] - pb[c]);
          d += s * s;
        end
        if (d < best) begin
          best = d;
          idx = {PAL_IDX[i], PAL_IDX[j]};
        end
      end
    end
    return idx;
  endfunction

  function automatic chan_t add_noise(chan_t ch, int base, int gain);
    int br, bg, bb, common;
    chan_t o;
    br = base;
    bg = base - NOISE_THIRD;
    if (bg < 0) bg += NOISE_MOD;
    bb = bg - NOISE_THIRD;
    if (bb < 0) bb += NOISE_MOD;
    br = br * 2 - (NOISE_MOD - 1);
    bg = bg * 2 - (NOISE_MOD - 1);
    bb = bb * 2 - (NOISE_MOD - 1);
    common = int'((longint'(br + bg + bb) * gain) >>> 16);
    o[0] = sat8(ch[0] + common + int'((longint'(br) * gain) >>> 16));
    o[1] = sat8(ch[1] + common + int'((longint'(bg) * gain) >>> 16));
    o[2] = sat8(ch[2] + common + int'((longint'(bb) * gain) >>> 16));
    return o;
  endfunction

  function automatic logic [7:0] quantize_pair(logic [15:0] left, logic [15:0] right,
                                               logic [8:0] col, logic [9:0] row);
    chan_t a, b;
    int x, y, b0, b1, base, gain;
    a = expand565(left);
    b = expand565(right);
    x = int'(col);
    y = int'(row);
    if (cur_mode == MODE_FASTEST) return {closest(a), closest(b)};
    if (cur_mode == MODE_FAST) begin
      b0 = ((ORDERED[y & 3][x & 3] * 2 - 255) * FAST_GAIN) >>> 8;
      b1 = ((ORDERED[y & 3][(x + 1) & 3] * 2 - 255) * FAST_GAIN) >>> 8;
      for (int c = 0; c < 3; c++) begin
        a[c] = sat8(a[c] + b0);
        b[c] = sat8(b[c] + b1);
      end
      return best_pair(a, b);
    end
    gain = (cur_mode == MODE_TEXT) ? int'(text_gain) : int'(quality_gain);
    base = modstep(longint'(y) * Y_STEP);
    base = modstep(longint'(base) - longint'(X_STEP) * (x + 1));
    a = add_noise(a, base, gain);
    base = modstep(longint'(base) - X_STEP);
    b = add_noise(b, base, gain);
    return best_pair(a, b);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      cur_mode     <= MODE_QUALITY;
      text_gain    <= TEXT_GAIN_RST;
      quality_gain <= QUALITY_GAIN_RST;
      expected_pairs.delete();
      fails        <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_MODE:         cur_mode <= mode_e'(cfg.data[1:0]);
          CFG_TEXT_GAIN:    text_gain <= cfg.data;
          CFG_QUALITY_GAIN: quality_gain <= cfg.data;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        expected_pairs.push_back(quantize_pair(pix.first_pixel, pix.second_pixel,
                                               pix.column, pix.row));
      if (res.valid && res.ready) begin
        if (expected_pairs.size() == 0) begin
          if (fails < 10) $display("unexpected result transaction: packed_pair %h",
                                   res.packed_pair);
          fails <= fails + 1;
        end else begin
          want = expected_pairs.pop_front();
          if (want !== res.packed_pair) begin
            if (fails < 10) $display("packed_pair mismatch: expected %h actual %h",
                                     want, res.packed_pair);
            fails <= fails + 1;
          end
        end
      end
    end
    depth = expected_pairs.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives pixel pairs and register writes, stalls results, reports verdict.
module testbench import rppd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic steady = 1'b0;
  int   fail_count, pending;

  rppd_in_if  pix();
  rppd_out_if res();
  rppd_cfg_if cfg();

  rgb565_pair_palette_ditherer DUT (.clk_i, .rst_ni, .pix_i(pix), .res_o(res), .cfg_i(cfg));

  rppd_checker checker_inst (.clk_i, .rst_ni, .pix, .res, .cfg,
                             .fail_count_o(fail_count), .pending_o(pending));

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pair(logic [15:0] left, logic [15:0] right, logic [8:0] col,
                           logic [9:0] row);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.first_pixel  = left;
    pix.second_pixel = right;
    pix.column       = col;
    pix.row          = row;
    pix.valid        = 1'b1;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg.index = idx;
    cfg.data  = data;
    cfg.valid = 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    pix.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_pixel();
    unique case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_pair();
    if ($urandom_range(0, 99) < 85)
      send_pair(pick_pixel(), pick_pixel(), 9'(2 * $urandom_range(0, 199)),
                10'($urandom_range(0, 599)));
    else
      send_pair(pick_pixel(), pick_pixel(), 9'($urandom), 10'($urandom));
  endtask

  always begin
    int stall;
    @(negedge clk_i);
    stall = steady ? 0 : $urandom_range(0, 8);
    if (stall > 0) begin
      res.ready = 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    res.ready = 1'b1;
    do @(posedge clk_i); while (!(res.valid && res.ready));
  end

  initial begin
    logic [7:0] tg, qg;
    pix.valid = 1'b0;
    pix.first_pixel = '0;
    pix.second_pixel = '0;
    pix.column = '0;
    pix.row = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_MODE;
    cfg.data = '0;
    res.ready = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: extremes, pure colors, odd and off-panel coordinates
    send_pair(16'h0000, 16'hffff, 9'd0, 10'd0);
    send_pair(16'hffff, 16'h0000, 9'd398, 10'd599);
    send_pair(16'hf800, 16'h07e0, 9'd1, 10'd3);
    send_pair(16'h001f, 16'hffe0, 9'd511, 10'd1023);
    send_pair(16'hbe00, 16'h6c1f, 9'd399, 10'd600);
    send_pair(16'h4443, 16'hff87, 9'd2, 10'd1);
    send_pair(16'h8410, 16'h8410, 9'd3, 10'd2);
    send_pair(16'h0841, 16'hf7de, 9'd256, 10'd512);
    send_pair(16'h7bef, 16'h7bef, 9'd255, 10'd511);
    repeat (6) random_pair();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      tg = (ph == 1) ? 8'd0 : (ph == 5) ? 8'd255 : 8'($urandom);
      qg = (ph == 0) ? 8'd255 : (ph == 4) ? 8'd0 : 8'($urandom);
      write_reg(CFG_MODE, 8'(mode_e'(ph % 4)));
      write_reg(CFG_TEXT_GAIN, tg);
      write_reg(CFG_QUALITY_GAIN, qg);
      steady = (ph % 3 == 2);
      if (ph < 4) begin
        // extremes under each mode
        send_pair(16'h0000, 16'hffff, 9'd1, 10'd0);
        send_pair(16'hffff, 16'h0000, 9'd511, 10'd1023);
      end
      repeat (240) random_pair();
      drain();
    end

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
